// File: design/sorted_key_merge_with_color_union_macros.svh
// Assertion macros for the sorted key merge block.
// Taken in by the top level; relies on a clock named clock and a reset named reset.
`ifndef SORTED_KEY_MERGE_WITH_COLOR_UNION_MACROS_SVH
`define SORTED_KEY_MERGE_WITH_COLOR_UNION_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define SKMC_ASSERT_SAME(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);

// Check a condition in the cycle after its trigger.
`define SKMC_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

// File: design/skmc_pkg.sv
// Shared types and constants for the sorted key merge block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package skmc_pkg;

   localparam int KEY_W      = 64;
   localparam int COLOR_W    = 64;
   localparam int QUEUE_DEPTH = 2;

   // Input item: one flag word plus the heads of both streams
   typedef struct packed {
      logic               req_type;
      logic               a_present;
      logic [KEY_W-1:0]   key_a;
      logic [COLOR_W-1:0] color_a;
      logic               b_present;
      logic [KEY_W-1:0]   key_b;
      logic [COLOR_W-1:0] color_b;
   } merge_req_type;

   // Result item
   typedef struct packed {
      logic               pop_a;
      logic               pop_b;
      logic               out_valid;
      logic [KEY_W-1:0]   out_key;
      logic [COLOR_W-1:0] out_color_a;
      logic [COLOR_W-1:0] out_color_b;
   } merge_rsp_type;

   // Request codes on the input
   localparam logic REQ_MERGE = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   // Operation handed from front to back
   typedef enum logic [1:0] {
      OP_IDLE,
      OP_TAKE,
      OP_FLUSH
   } merge_op_type;

   // Classified item held in the queue
   typedef struct packed {
      merge_op_type       op;
      logic               take_a;
      logic [KEY_W-1:0]   key;
      logic [COLOR_W-1:0] color;
   } qent_type;

   // Queue status toward the top level
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// File: design/skmc_front.sv
// Front end: classifies an input item and picks the winning head.
// Depends on skmc_pkg.
`timescale 1ns / 1ps

module skmc_front (
   input  skmc_pkg::merge_req_type req_data,
   output skmc_pkg::qent_type      ent
);

   logic take_a;

   // Pick A only when it is present and B is absent or larger; ties go to B
   assign take_a = req_data.a_present &&
                   (!req_data.b_present || (req_data.key_a < req_data.key_b));

   // Classify the item
   always_comb begin
      ent        = '0;
      ent.op     = skmc_pkg::OP_IDLE;
      ent.take_a = take_a;
      ent.key    = take_a ? req_data.key_a : req_data.key_b;
      ent.color  = take_a ? req_data.color_a : req_data.color_b;
      if (req_data.req_type == skmc_pkg::REQ_FLUSH) begin
         ent.op = skmc_pkg::OP_FLUSH;
      end else if (req_data.a_present || req_data.b_present) begin
         ent.op = skmc_pkg::OP_TAKE;
      end
   end

endmodule

// File: design/skmc_queue.sv
// Short queue of classified items between front and back.
// Depends on skmc_pkg.
`timescale 1ns / 1ps

module skmc_queue #(
   parameter int DEPTH = skmc_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  skmc_pkg::qent_type  din,
   input  logic                pop,
   output skmc_pkg::qent_type  dout,
   output skmc_pkg::qstat_type stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   skmc_pkg::qent_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign stat.full  = (count_ff == FULL_CNT);
   assign stat.empty = (count_ff == '0);
   assign dout       = entry_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// File: design/skmc_back.sv
// Back end: holds the pending record, combines equal keys and drives the result register.
// Depends on skmc_pkg.
`timescale 1ns / 1ps

module skmc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  skmc_pkg::qent_type      ent,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output skmc_pkg::merge_rsp_type rsp_data
);

   logic                            pend_valid_ff, pend_valid_in;
   logic [skmc_pkg::KEY_W-1:0]      pend_key_ff, pend_key_in;
   logic [skmc_pkg::COLOR_W-1:0]    pend_color_a_ff, pend_color_a_in;
   logic [skmc_pkg::COLOR_W-1:0]    pend_color_b_ff, pend_color_b_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   skmc_pkg::merge_rsp_type         rsp_data_ff, rsp_data_in;
   skmc_pkg::merge_rsp_type         result;
   logic                            hit;

   // Take the next item whenever the result register frees up
   assign q_pop     = q_valid && (!rsp_valid_ff || rsp_ready);
   assign hit       = pend_valid_ff && (ent.key == pend_key_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Apply item to the pending record
   always_comb begin
      result          = '0;
      pend_valid_in   = pend_valid_ff;
      pend_key_in     = pend_key_ff;
      pend_color_a_in = pend_color_a_ff;
      pend_color_b_in = pend_color_b_ff;
      unique case (ent.op)
         skmc_pkg::OP_FLUSH: begin
            if (pend_valid_ff) begin
               result.out_valid   = 1'b1;
               result.out_key     = pend_key_ff;
               result.out_color_a = pend_color_a_ff;
               result.out_color_b = pend_color_b_ff;
            end
            pend_valid_in = 1'b0;
         end
         skmc_pkg::OP_TAKE: begin
            result.pop_a = ent.take_a;
            result.pop_b = !ent.take_a;
            if (hit) begin
               if (ent.take_a) begin
                  pend_color_a_in = ent.color;
               end else begin
                  pend_color_b_in = ent.color;
               end
            end else begin
               if (pend_valid_ff) begin
                  result.out_valid   = 1'b1;
                  result.out_key     = pend_key_ff;
                  result.out_color_a = pend_color_a_ff;
                  result.out_color_b = pend_color_b_ff;
               end
               pend_valid_in   = 1'b1;
               pend_key_in     = ent.key;
               pend_color_a_in = ent.take_a ? ent.color : '0;
               pend_color_b_in = ent.take_a ? '0 : ent.color;
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

   // Load result register on pop, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (q_pop) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            pend_valid_ff <= pend_valid_in;
         end
      end
   end

   // Hold payload unless an item is applied
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (q_pop) begin
         pend_key_ff     <= pend_key_in;
         pend_color_a_ff <= pend_color_a_in;
         pend_color_b_ff <= pend_color_b_in;
      end
   end

endmodule

// File: design/sorted_key_merge_with_color_union.sv
// Channel  | Ports                           | Moves
// req      | req_valid, req_ready, req_data  | stream heads or flush, one item
// rsp      | rsp_valid, rsp_ready, rsp_data  | pop flags and emitted record, one item
//
// One item per cycle unless rsp_ready stalls; the queue feeds a result register.
// The 64-bit key compare sits in the front, the equal-key check in the back.
// A queue of QUEUE_DEPTH items decouples them; req_ready drops only when it is full.
// Synchronous active-high reset clears the queue, pending record and result register.
// Depends on skmc_pkg, skmc_front, skmc_queue, skmc_back and the macros header.
`timescale 1ns / 1ps
`include "sorted_key_merge_with_color_union_macros.svh"

module sorted_key_merge_with_color_union #(
   parameter int QUEUE_DEPTH = skmc_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  skmc_pkg::merge_req_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output skmc_pkg::merge_rsp_type rsp_data
);

   skmc_pkg::qent_type  front_ent;
   skmc_pkg::qent_type  back_ent;
   skmc_pkg::qstat_type q_stat;
   logic                q_push;
   logic                q_pop;

   assign req_ready = !q_stat.full;
   assign q_push    = req_valid && req_ready;

   skmc_front u_front (
      .req_data (req_data),
      .ent      (front_ent)
   );

   skmc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (front_ent),
      .pop   (q_pop),
      .dout  (back_ent),
      .stat  (q_stat)
   );

   skmc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (!q_stat.empty),
      .ent       (back_ent),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `SKMC_ASSERT_SAME(a_queue_state, 1'b1, !(q_stat.full && q_stat.empty), "queue full and empty")
   `SKMC_ASSERT_NEXT(a_push_lands, q_push, !q_stat.empty, "accepted item missing from queue")
   `SKMC_ASSERT_SAME(a_no_emit_zero, rsp_valid && !rsp_data.out_valid, (rsp_data.out_key == '0) && (rsp_data.out_color_a == '0) && (rsp_data.out_color_b == '0), "fields set without emission")
   `SKMC_ASSERT_SAME(a_one_pop, rsp_valid, !(rsp_data.pop_a && rsp_data.pop_b), "both heads popped")

endmodule
